// ----- sv/pi_current_regulator_defines.svh -----
// ----------------------------------------------------------------------------
// pi_current_regulator_defines
// assertion macros shared by the pi current regulator modules
// ----------------------------------------------------------------------------
`ifndef PI_CURRENT_REGULATOR_DEFINES_SVH
`define PI_CURRENT_REGULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define PIRC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pi regulator check failed");
// consequent checked in the cycle after the antecedent
`define PIRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pi regulator sequence check failed");
`else
`define PIRC_ASSERT(lbl, prop)
`define PIRC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/pirc_pkg.sv -----
// ----------------------------------------------------------------------------
// pirc_pkg
// types and constants of the pi current regulator
// ----------------------------------------------------------------------------
`default_nettype none

package pirc_pkg;

	localparam int FRACTION_BITS_DEF = 20;
	localparam int SAMPLE_W          = 12;
	localparam int ERR_W             = SAMPLE_W + 1;
	localparam int COEF_W            = 24;
	localparam int IN_DATA_W         = 24;
	localparam int OUT_DATA_W        = 16;
	localparam int CFG_IDX_W         = 1;

	localparam logic signed [COEF_W-1:0] COEF_CUR_RST  = 24'sd632;
	localparam logic signed [COEF_W-1:0] COEF_PREV_RST = -24'sd550;
	localparam logic signed [ERR_W-1:0]  DUTY_FULL     = 13'sd4095;

	localparam logic [CFG_IDX_W-1:0] CFG_COEF_CURRENT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREVIOUS = 1'b1;

	// operand select of the shared multiplier
	typedef enum logic [1:0] {
		MSEL_CUR,
		MSEL_PREV,
		MSEL_DUTY
	} mul_sel_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum_load;
		logic     sum_add;
		logic     clamp_en;
		logic     out_load;
	} mac_ctl_t;

endpackage

`default_nettype wire

// ----- sv/pirc_dp.sv -----
// ----------------------------------------------------------------------------
// pirc_dp
// datapath: error, shared multiplier, accumulator with clamp, duty scaling
// ----------------------------------------------------------------------------
`default_nettype none
`include "pi_current_regulator_defines.svh"

module pirc_dp #(
	parameter int FRACTION_BITS = pirc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pirc_pkg::mac_ctl_t                  ctl,
	input  wire logic [pirc_pkg::SAMPLE_W-1:0]       setpoint_sample,
	input  wire logic [pirc_pkg::SAMPLE_W-1:0]       measured_sample,
	input  wire logic signed [pirc_pkg::COEF_W-1:0]  coef_current,
	input  wire logic signed [pirc_pkg::COEF_W-1:0]  coef_previous,
	output logic [pirc_pkg::SAMPLE_W-1:0]            duty,
	output logic                                     limited
);
	import pirc_pkg::*;

	localparam int AW = FRACTION_BITS + 1;
	localparam int MA = (COEF_W > FRACTION_BITS + 2) ? COEF_W : FRACTION_BITS + 2;
	localparam int PW = MA + ERR_W;
	localparam int SW = PW + 2;
	localparam logic signed [AW:0]   HALF_E = (AW+1)'(64'sd1 <<< (FRACTION_BITS - 1));
	localparam logic signed [SW-1:0] HALF_S = SW'(HALF_E);

	logic signed [ERR_W-1:0] err_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [AW-1:0]    acc_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [SW-1:0]    sum_q;
	logic                    lim_q;
	logic [SAMPLE_W-1:0]     duty_q;
	logic                    lim_out_q;

	logic signed [AW:0]      acc_plus;
	logic signed [MA-1:0]    mul_a;
	logic signed [ERR_W-1:0] mul_b;
	logic signed [AW-1:0]    acc_nxt;
	logic                    lim_nxt;

	assign acc_plus = $signed({acc_q[AW-1], acc_q}) + HALF_E;

	always_comb begin
		unique case (ctl.mul_sel)
			MSEL_CUR: begin
				mul_a = MA'(coef_current);
				mul_b = err_q;
			end
			MSEL_PREV: begin
				mul_a = MA'(coef_previous);
				mul_b = prev_err_q;
			end
			MSEL_DUTY: begin
				mul_a = MA'(acc_plus);
				mul_b = DUTY_FULL;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		if (sum_q > HALF_S) begin
			acc_nxt = AW'(HALF_S);
			lim_nxt = 1'b1;
		end else if (sum_q < -HALF_S) begin
			acc_nxt = AW'(-HALF_S);
			lim_nxt = 1'b1;
		end else begin
			acc_nxt = AW'(sum_q);
			lim_nxt = 1'b0;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			prev_err_q <= '0;
			lim_q      <= 1'b0;
		end else if (ctl.clamp_en) begin
			acc_q      <= acc_nxt;
			prev_err_q <= err_q;
			lim_q      <= lim_nxt;
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			err_q <= $signed({1'b0, setpoint_sample}) - $signed({1'b0, measured_sample});
		end
		if (ctl.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (ctl.sum_load) begin
			sum_q <= SW'(acc_q);
		end else if (ctl.sum_add) begin
			sum_q <= sum_q + SW'(prod_q);
		end
		if (ctl.out_load) begin
			duty_q    <= prod_q[FRACTION_BITS +: SAMPLE_W];
			lim_out_q <= lim_q;
		end
	end

	assign duty    = duty_q;
	assign limited = lim_out_q;

	`PIRC_ASSERT(a_acc_bounded, (SW'(acc_q) <= HALF_S) && (SW'(acc_q) >= -HALF_S))
	`PIRC_ASSERT_NEXT(a_prev_err_update, ctl.clamp_en, prev_err_q == $past(err_q))
	`PIRC_ASSERT_NEXT(a_no_limit_inside, ctl.clamp_en && (sum_q <= HALF_S) && (sum_q >= -HALF_S), !lim_q)

endmodule

`default_nettype wire

// ----- sv/pirc_seq.sv -----
// ----------------------------------------------------------------------------
// pirc_seq
// sequencer that steps the shared multiplier through one regulator update
// ----------------------------------------------------------------------------
`default_nettype none
`include "pi_current_regulator_defines.svh"

module pirc_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output pirc_pkg::mac_ctl_t ctl
);
	import pirc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_CUR,
		ST_MUL_PREV,
		ST_ADD,
		ST_CLAMP,
		ST_MUL_DUTY,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   s_tready_q;
	logic   m_tvalid_q;
	logic   accept;
	logic   out_free;

	assign accept   = s_tvalid && s_tready_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		ctl          = '0;
		ctl.mul_sel  = MSEL_CUR;
		ctl.capture  = accept;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_MUL_CUR: begin
				ctl.mul_en   = 1'b1;
				ctl.mul_sel  = MSEL_CUR;
				ctl.sum_load = 1'b1;
			end
			ST_MUL_PREV: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MSEL_PREV;
				ctl.sum_add = 1'b1;
			end
			ST_ADD: begin
				ctl.sum_add = 1'b1;
			end
			ST_CLAMP: begin
				ctl.clamp_en = 1'b1;
			end
			ST_MUL_DUTY: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MSEL_DUTY;
			end
			ST_DONE: begin
				ctl.out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			s_tready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			// new result loads, else a taken result clears
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_MUL_CUR;
						s_tready_q <= 1'b0;
					end
				end
				ST_MUL_CUR:  state_q <= ST_MUL_PREV;
				ST_MUL_PREV: state_q <= ST_ADD;
				ST_ADD:      state_q <= ST_CLAMP;
				ST_CLAMP:    state_q <= ST_MUL_DUTY;
				ST_MUL_DUTY: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q    <= ST_IDLE;
						s_tready_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;

	`PIRC_ASSERT(a_ready_only_idle, s_tready_q |-> (state_q == ST_IDLE))
	`PIRC_ASSERT_NEXT(a_accept_starts, accept, (state_q == ST_MUL_CUR) && !s_tready_q)
	`PIRC_ASSERT_NEXT(a_done_waits, (state_q == ST_DONE) && m_tvalid_q && !m_tready, state_q == ST_DONE)
	`PIRC_ASSERT_NEXT(a_load_sets_valid, ctl.out_load, m_tvalid_q && s_tready_q)

endmodule

`default_nettype wire

// ----- sv/pi_current_regulator.sv -----
// ----------------------------------------------------------------------------
// pi_current_regulator
// incremental pi current regulator with clamped accumulator and pwm duty out
// ----------------------------------------------------------------------------
// One input item is a setpoint and a measured-current adc sample. The block
// forms the error, adds coef_current * error + coef_previous * previous error
// to a fixed-point accumulator (FRACTION_BITS fraction bits), clamps it to
// plus or minus one half and returns duty = floor((acc + 0.5) * 4095) with a
// flag that tells whether the clamp acted. One signed multiplier is shared by
// the two coefficient products and the duty scaling, stepped by a small
// sequencer through MUL_CUR, MUL_PREV, ADD, CLAMP, MUL_DUTY and DONE. In
// DONE the result is loaded into the output register once the output side
// is free, and only then can the next item be taken; the input stays not
// ready from acceptance until then. A finished result may wait in the output
// register while the next item is taken in.
`default_nettype none

module pi_current_regulator #(
	parameter int FRACTION_BITS = pirc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// setpoint_sample [11:0], measured_sample [23:12]
	input  wire logic [pirc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// duty [11:0], limited [12], zero fill [15:13]
	output logic [pirc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [pirc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pirc_pkg::COEF_W-1:0]       cfg_data
);
	import pirc_pkg::*;

	logic signed [COEF_W-1:0] coef_cur_q;
	logic signed [COEF_W-1:0] coef_prev_q;
	mac_ctl_t                 ctl;
	logic [SAMPLE_W-1:0]      duty;
	logic                     limited;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_cur_q  <= COEF_CUR_RST;
			coef_prev_q <= COEF_PREV_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COEF_CURRENT:  coef_cur_q  <= $signed(cfg_data);
				CFG_COEF_PREVIOUS: coef_prev_q <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	pirc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.ctl      (ctl)
	);

	pirc_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.setpoint_sample (s_axis_tdata[SAMPLE_W-1:0]),
		.measured_sample (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.coef_current    (coef_cur_q),
		.coef_previous   (coef_prev_q),
		.duty            (duty),
		.limited         (limited)
	);

	assign m_axis_tdata = {{(OUT_DATA_W - SAMPLE_W - 1){1'b0}}, limited, duty};

endmodule

`default_nettype wire
